FILE: rtl/integer_text_parser_top_assert.svh
// ----------------------------------------------------------------------------
// integer_text_parser_top_assert
// assertion macros for the integer text parser
// ----------------------------------------------------------------------------
`ifndef INTEGER_TEXT_PARSER_TOP_ASSERT_SVH
`define INTEGER_TEXT_PARSER_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// property checked out of reset
`define ITP_ASSERT(name, clk, rstn, prop) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("integer_text_parser: check failed");

// property checked during reset as well
`define ITP_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("integer_text_parser: check failed");

`else

`define ITP_ASSERT(name, clk, rstn, prop)
`define ITP_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

FILE: rtl/itp_pkg.sv
// ----------------------------------------------------------------------------
// itp_pkg
// shared types and constants of the integer text parser
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int MAX_CHARS   = 4096;
  localparam int POS_W       = $clog2(MAX_CHARS + 1);
  localparam int CHAR_W      = 8;
  localparam int BASE_W      = 6;
  localparam int VALUE_W     = 64;
  localparam int STATUS_W    = 2;
  localparam int OUT_W       = VALUE_W + STATUS_W + POS_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = BASE_W;

  localparam logic [CFG_IDX_W-1:0] REG_NUMBER_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_UNSIGNED_MODE = 1'd1;

  localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_NO_CONV = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_RANGE   = 2'd2;

  typedef enum logic [1:0] {
    BASE_KEEP,
    BASE_FIRST,
    BASE_HEX
  } base_op_e;

  typedef struct packed {
    logic     accept;
    logic     attempt;
    base_op_e base_op;
    logic     set_neg;
    logic     finish;
  } itp_cmd_t;

  typedef struct packed {
    logic white;
    logic minus;
    logic plus;
    logic xchar;
    logic hex;
    logic zero_first;
    logic first_ok;
    logic digit_ok;
  } itp_status_t;

endpackage

FILE: rtl/itp_datapath.sv
// ----------------------------------------------------------------------------
// itp_datapath
// character classes, accumulator with overflow check, result register
// ----------------------------------------------------------------------------
module itp_datapath import itp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic [CHAR_W-1:0]      char_i,
  input  itp_cmd_t               cmd_i,
  output itp_status_t            status_o,
  output logic [OUT_TDATA_W-1:0] out_data_o
);

  localparam logic [VALUE_W-1:0] LIM_SIGNED   = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic [VALUE_W-1:0] LIM_NEGATIVE = {1'b1, {(VALUE_W-1){1'b0}}};
  localparam logic [VALUE_W-1:0] LIM_UNSIGNED = {VALUE_W{1'b1}};
  localparam logic [POS_W-1:0]   POS_MAX      = POS_W'(MAX_CHARS);

  logic [BASE_W-1:0]  base_q, base_d;
  logic               unsigned_q, unsigned_d;
  logic               neg_q, neg_d;
  logic [BASE_W-1:0]  active_q, active_d;
  logic [VALUE_W-1:0] acc_q, acc_d;
  logic               any_q, any_d;
  logic               ovf_q, ovf_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [POS_W-1:0]   dend_q, dend_d;
  logic [OUT_W-1:0]   out_q, out_d;

  logic                      dig_valid;
  logic [BASE_W-1:0]         dig_val;
  logic                      zero_first;
  logic [BASE_W-1:0]         first_base;
  logic [BASE_W-1:0]         eff_base;
  logic                      digit_ok;
  logic [VALUE_W-1:0]        limit;
  logic [VALUE_W+BASE_W-1:0] prod;
  logic                      take;
  logic [POS_W-1:0]          pos_after;
  logic [VALUE_W-1:0]        res_value;
  logic [STATUS_W-1:0]       res_status;
  logic [POS_W-1:0]          res_offset;

  function automatic logic radix_ok(input logic              valid,
                                    input logic [BASE_W-1:0] v,
                                    input logic [BASE_W-1:0] b);
    return valid && (b >= BASE_W'(2)) && (b <= BASE_W'(36)) && (v < b);
  endfunction

  // digit value of the character
  always_comb begin
    dig_valid = 1'b1;
    dig_val   = '0;
    if (char_i inside {[8'h30:8'h39]}) begin
      dig_val = BASE_W'(char_i - 8'h30);
    end else if (char_i inside {[8'h41:8'h5a]}) begin
      dig_val = BASE_W'(char_i - 8'h37);
    end else if (char_i inside {[8'h61:8'h7a]}) begin
      dig_val = BASE_W'(char_i - 8'h57);
    end else begin
      dig_valid = 1'b0;
    end
  end

  assign zero_first = (char_i == 8'h30) &&
                      ((base_q == BASE_W'(0)) || (base_q == BASE_W'(16)));

  // radix for the first character of a number
  always_comb begin
    if (zero_first) begin
      first_base = (base_q == BASE_W'(16)) ? BASE_W'(16) : BASE_W'(8);
    end else begin
      first_base = (base_q == BASE_W'(0)) ? BASE_W'(10) : base_q;
    end
  end

  always_comb begin
    status_o.white      = char_i inside {8'h20, [8'h09:8'h0d]};
    status_o.minus      = (char_i == 8'h2d);
    status_o.plus       = (char_i == 8'h2b);
    status_o.xchar      = (char_i == 8'h78) || (char_i == 8'h58);
    status_o.hex        = char_i inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]};
    status_o.zero_first = zero_first;
    status_o.first_ok   = radix_ok(dig_valid, dig_val, first_base);
    status_o.digit_ok   = radix_ok(dig_valid, dig_val, active_q);
  end

  // radix in force for this character
  always_comb begin
    case (cmd_i.base_op)
      BASE_FIRST: eff_base = first_base;
      BASE_HEX:   eff_base = BASE_W'(16);
      default:    eff_base = active_q;
    endcase
  end

  assign digit_ok = radix_ok(dig_valid, dig_val, eff_base);

  assign limit = unsigned_q ? LIM_UNSIGNED : (neg_q ? LIM_NEGATIVE : LIM_SIGNED);
  assign prod  = ({{BASE_W{1'b0}}, acc_q} * {{VALUE_W{1'b0}}, eff_base}) +
                 {{VALUE_W{1'b0}}, dig_val};
  assign take      = cmd_i.accept && cmd_i.attempt && digit_ok;
  assign pos_after = (pos_q < POS_MAX) ? pos_q + POS_W'(1) : POS_MAX;

  // result word
  always_comb begin
    if (!any_q) begin
      res_value  = '0;
      res_status = STATUS_NO_CONV;
      res_offset = '0;
    end else if (ovf_q) begin
      res_value  = limit;
      res_status = STATUS_RANGE;
      res_offset = dend_q;
    end else begin
      res_value  = neg_q ? VALUE_W'(0) - acc_q : acc_q;
      res_status = STATUS_OK;
      res_offset = dend_q;
    end
  end

  always_comb begin
    base_d     = base_q;
    unsigned_d = unsigned_q;
    neg_d      = neg_q;
    active_d   = active_q;
    acc_d      = acc_q;
    any_d      = any_q;
    ovf_d      = ovf_q;
    pos_d      = pos_q;
    dend_d     = dend_q;
    out_d      = out_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_NUMBER_BASE:   base_d     = cfg_data_i;
        REG_UNSIGNED_MODE: unsigned_d = cfg_data_i[0];
        default: ;
      endcase
    end
    if (cmd_i.finish) begin
      out_d    = {res_offset, res_status, res_value};
      neg_d    = 1'b0;
      active_d = '0;
      acc_d    = '0;
      any_d    = 1'b0;
      ovf_d    = 1'b0;
      pos_d    = '0;
      dend_d   = '0;
    end else if (cmd_i.accept) begin
      pos_d = pos_after;
      if (cmd_i.set_neg) begin
        neg_d = 1'b1;
      end
      if (cmd_i.base_op != BASE_KEEP) begin
        active_d = eff_base;
      end
      if (take) begin
        any_d  = 1'b1;
        dend_d = pos_after;
        if (ovf_q || (prod > {{BASE_W{1'b0}}, limit})) begin
          ovf_d = 1'b1;
        end else begin
          acc_d = prod[VALUE_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q     <= BASE_W'(10);
      unsigned_q <= 1'b0;
      neg_q      <= 1'b0;
      active_q   <= '0;
      acc_q      <= '0;
      any_q      <= 1'b0;
      ovf_q      <= 1'b0;
      pos_q      <= '0;
      dend_q     <= '0;
    end else begin
      base_q     <= base_d;
      unsigned_q <= unsigned_d;
      neg_q      <= neg_d;
      active_q   <= active_d;
      acc_q      <= acc_d;
      any_q      <= any_d;
      ovf_q      <= ovf_d;
      pos_q      <= pos_d;
      dend_q     <= dend_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_data_o = {{(OUT_TDATA_W-OUT_W){1'b0}}, out_q};

endmodule

FILE: rtl/itp_controller.sv
// ----------------------------------------------------------------------------
// itp_controller
// parse phase sequencer and stream handshake control
// ----------------------------------------------------------------------------
module itp_controller import itp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tlast_i,
  output logic        s_tready_o,
  input  logic        m_tready_i,
  output logic        m_tvalid_o,
  input  itp_status_t status_i,
  output itp_cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    PH_SPACE,
    PH_SIGN,
    PH_ZERO,
    PH_XPEND,
    PH_DIGITS,
    PH_DONE,
    PH_FINISH
  } phase_e;

  phase_e phase_q, phase_d;
  logic   out_valid_q, out_valid_d;

  assign s_tready_o = (phase_q != PH_FINISH);
  assign m_tvalid_o = out_valid_q;

  always_comb begin
    cmd_o         = '0;
    cmd_o.base_op = BASE_KEEP;
    cmd_o.accept  = s_tvalid_i && (phase_q != PH_FINISH);
    phase_d       = phase_q;
    out_valid_d   = out_valid_q && !m_tready_i;
    if (phase_q == PH_FINISH) begin
      if (!out_valid_q || m_tready_i) begin
        cmd_o.finish = 1'b1;
        out_valid_d  = 1'b1;
        phase_d      = PH_SPACE;
      end
    end else if (cmd_o.accept) begin
      case (phase_q)
        PH_SPACE, PH_SIGN: begin
          if ((phase_q == PH_SPACE) && status_i.white) begin
            phase_d = PH_SPACE;
          end else if ((phase_q == PH_SPACE) && status_i.minus) begin
            cmd_o.set_neg = 1'b1;
            phase_d       = PH_SIGN;
          end else if ((phase_q == PH_SPACE) && status_i.plus) begin
            phase_d = PH_SIGN;
          end else begin
            cmd_o.attempt = 1'b1;
            cmd_o.base_op = BASE_FIRST;
            if (status_i.zero_first) begin
              phase_d = PH_ZERO;
            end else begin
              phase_d = status_i.first_ok ? PH_DIGITS : PH_DONE;
            end
          end
        end
        PH_ZERO: begin
          if (status_i.xchar) begin
            phase_d = PH_XPEND;
          end else begin
            cmd_o.attempt = 1'b1;
            phase_d       = status_i.digit_ok ? PH_DIGITS : PH_DONE;
          end
        end
        PH_XPEND: begin
          if (status_i.hex) begin
            cmd_o.attempt = 1'b1;
            cmd_o.base_op = BASE_HEX;
            phase_d       = PH_DIGITS;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_DIGITS: begin
          cmd_o.attempt = 1'b1;
          if (!status_i.digit_ok) begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
      if (s_tlast_i) begin
        phase_d = PH_FINISH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_SPACE;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

FILE: rtl/integer_text_parser_top.sv
// ----------------------------------------------------------------------------
// integer_text_parser_top
// streaming text to 64-bit integer converter, one character per word
// result: the word marked last moves the parser to its finish phase, in which
// the result word is registered; one character per cycle outside that phase
// the finish phase waits while the previous result word is still held
// reset: asynchronous active low, base 10, signed mode, parser idle
// ----------------------------------------------------------------------------
`include "integer_text_parser_top_assert.svh"

module integer_text_parser_top import itp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [CHAR_W-1:0]      s_axis_tdata,  // text_char
  input  logic                   s_axis_tlast,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // parsed_value, parse_status, end_offset
);

  itp_cmd_t    cmd;
  itp_status_t status;
  logic        last_acc;

  itp_controller u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tlast_i  (s_axis_tlast),
    .s_tready_o (s_axis_tready),
    .m_tready_i (m_axis_tready),
    .m_tvalid_o (m_axis_tvalid),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  itp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .char_i      (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (m_axis_tdata)
  );

  assign last_acc = s_axis_tvalid && s_axis_tready && s_axis_tlast;

  `ITP_ASSERT(a_last_blocks_input, clk_i, rst_ni, last_acc |=> !s_axis_tready)
  `ITP_ASSERT(a_finish_gives_word, clk_i, rst_ni, cmd.finish |=> m_axis_tvalid)
  `ITP_ASSERT(a_finish_not_accept, clk_i, rst_ni, cmd.finish |-> (!s_axis_tready && !cmd.accept))
  `ITP_ASSERT_ALWAYS(a_no_word_after_reset, clk_i, !rst_ni |=> !m_axis_tvalid)

endmodule
